>>> rtl/quadrature_encoder_debounced_counter_core_macros.svh
// Assertion macros shared by the encoder counter RTL.
`ifndef QUADRATURE_ENCODER_DEBOUNCED_COUNTER_CORE_MACROS_SVH
`define QUADRATURE_ENCODER_DEBOUNCED_COUNTER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every clock edge outside reset.
`define QEDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qedc assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define QEDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qedc assertion failed");

`else

`define QEDC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QEDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/qedc_pkg.sv
// Package with types, constants and the quadrature table of the encoder counter.
`default_nettype none

package qedc_pkg;

	// Command codes carried by each input transaction.
	typedef enum logic [1:0] {
		CMD_EDGE    = 2'd0,
		CMD_CONSUME = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_CAPTURE = 2'd3
	} qedc_cmd_t;

	localparam int CNT_W     = 32;
	localparam int TIME_W    = 32;
	localparam int DEB_W     = 16;
	localparam int STEP_W    = 4;
	localparam int QEDC_CLAMP = 4;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd1000;

	// Clamp limits at counter and step widths.
	localparam logic signed [CNT_W-1:0]  CLAMP_CNT  = CNT_W'(QEDC_CLAMP);
	localparam logic signed [STEP_W-1:0] CLAMP_STEP = STEP_W'(QEDC_CLAMP);

	// Count step indexed by {old A, old B, new A, new B}.
	localparam logic signed [1:0] QUAD_TABLE [16] = '{
		 2'sd0, -2'sd1,  2'sd1,  2'sd0,
		 2'sd1,  2'sd0,  2'sd0, -2'sd1,
		-2'sd1,  2'sd0,  2'sd0,  2'sd1,
		 2'sd0,  2'sd1, -2'sd1,  2'sd0
	};

	// One input transaction as held in the input register.
	typedef struct packed {
		qedc_cmd_t                cmd;
		logic [TIME_W-1:0]        time_us;
		logic [1:0]               pins;
		logic signed [CNT_W-1:0]  load_value;
	} qedc_item_t;

	// One result transaction.
	typedef struct packed {
		logic signed [CNT_W-1:0]  position;
		logic signed [STEP_W-1:0] step_delta;
		logic                     delta_valid;
		logic                     edge_taken;
	} qedc_result_t;

endpackage

`default_nettype wire

>>> rtl/qedc_in_stage.sv
// Input register stage of the encoder counter.
`default_nettype none

module qedc_in_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire qedc_pkg::qedc_item_t in_item,
	input  wire logic                 advance,
	output logic                      valid_s1,
	output qedc_pkg::qedc_item_t      item_s1
);
	import qedc_pkg::*;

	// The stage holds only while its item cannot move on.
	assign in_stall = valid_s1 && !advance;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register, loaded with each accepted transaction.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/qedc_update.sv
// Encoder state, debounce register, update logic and result register.
`default_nettype none
`include "quadrature_encoder_debounced_counter_core_macros.svh"

module qedc_update (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [qedc_pkg::DEB_W-1:0] cfg_wr_data,
	input  wire logic                    valid_s1,
	input  wire qedc_pkg::qedc_item_t    item_s1,
	output logic                         advance,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output qedc_pkg::qedc_result_t       result
);
	import qedc_pkg::*;

	logic [DEB_W-1:0]         debounce_q;
	logic signed [CNT_W-1:0]  position_q;
	logic [1:0]               pins_q;
	logic [TIME_W-1:0]        last_edge_q;
	logic signed [CNT_W-1:0]  consumed_q;

	logic signed [CNT_W-1:0]  position_d;
	logic [1:0]               pins_d;
	logic [TIME_W-1:0]        last_edge_d;
	logic signed [CNT_W-1:0]  consumed_d;
	logic [TIME_W-1:0]        elapsed;
	logic signed [CNT_W-1:0]  diff;
	logic signed [1:0]        quad_step;
	qedc_result_t             result_d;
	logic                     out_valid_q;
	qedc_result_t             result_q;
	logic                     fire;

	// The result register frees up when empty or when its transaction leaves.
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign elapsed   = item_s1.time_us - last_edge_q;
	assign diff      = position_q - consumed_q;
	assign quad_step = QUAD_TABLE[{pins_q, item_s1.pins}];

	// Next state and result for the item in the input register.
	always_comb begin
		position_d           = position_q;
		pins_d               = pins_q;
		last_edge_d          = last_edge_q;
		consumed_d           = consumed_q;
		result_d.step_delta  = '0;
		result_d.delta_valid = 1'b0;
		result_d.edge_taken  = 1'b0;
		unique case (item_s1.cmd)
			CMD_EDGE: begin
				if (elapsed >= TIME_W'(debounce_q)) begin
					last_edge_d         = item_s1.time_us;
					position_d          = position_q + {{(CNT_W-2){quad_step[1]}}, quad_step};
					pins_d              = item_s1.pins;
					result_d.edge_taken = 1'b1;
				end
			end
			CMD_CONSUME: begin
				if (diff != '0) begin
					if (diff > CLAMP_CNT) begin
						result_d.step_delta = CLAMP_STEP;
					end else if (diff < -CLAMP_CNT) begin
						result_d.step_delta = -CLAMP_STEP;
					end else begin
						result_d.step_delta = diff[STEP_W-1:0];
					end
					consumed_d           = position_q;
					result_d.delta_valid = 1'b1;
				end
			end
			CMD_LOAD: begin
				position_d = item_s1.load_value;
			end
			CMD_CAPTURE: begin
				pins_d = item_s1.pins;
			end
		endcase
		result_d.position = position_d;
	end

	// Debounce configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			debounce_q <= cfg_wr_data;
		end
	end

	// Encoder state, updated once per transaction that moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			pins_q      <= '0;
			last_edge_q <= '0;
			consumed_q  <= '0;
		end else if (fire) begin
			position_q  <= position_d;
			pins_q      <= pins_d;
			last_edge_q <= last_edge_d;
			consumed_q  <= consumed_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	// A reported delta is never zero and stays within the clamp.
	`QEDC_ASSERT_NOW(a_delta_nonzero, clk, arst_n, out_valid_q && result_q.delta_valid, result_q.step_delta != '0)
	`QEDC_ASSERT_NOW(a_delta_range, clk, arst_n, out_valid_q, result_q.step_delta <= CLAMP_STEP && result_q.step_delta >= -CLAMP_STEP)
	// An edge and a consume never report in the same result.
	`QEDC_ASSERT_NOW(a_flags_exclusive, clk, arst_n, out_valid_q, !(result_q.edge_taken && result_q.delta_valid))
	// A taken edge records its timestamp.
	`QEDC_ASSERT_NEXT(a_edge_time, clk, arst_n, fire && result_d.edge_taken, last_edge_q == $past(item_s1.time_us))
	// A result register that is stalled keeps its transaction.
	`QEDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && result_q == $past(result_q))

endmodule

`default_nettype wire

>>> rtl/quadrature_encoder_debounced_counter_core.sv
// Top level of the debounced 4x quadrature encoder counter.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  input    | in        | in_valid / in_stall       | command time_us pin_a pin_b load_value
//  output   | out       | out_valid / out_stall     | position step_delta delta_valid edge_taken
//  config   | in        | cfg_wr_en                 | cfg_wr_data (debounce_us)
//
// One transaction is accepted per cycle while in_stall is low; its result passes through
// the input register and then the output register, where out_stall can hold it.
// The state update is one table lookup plus 32-bit subtracts, compares and an add.
// arst_n clears the count, pin and time state and sets the debounce to 1000 us.
// A stalled output holds its result; in_stall rises only when both registers are full
// and out_stall is high.
`default_nettype none

module quadrature_encoder_debounced_counter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] time_us,
	input  wire logic        pin_a,
	input  wire logic        pin_b,
	input  wire logic signed [31:0] load_value,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] position,
	output logic signed [3:0] step_delta,
	output logic             delta_valid,
	output logic             edge_taken
);
	import qedc_pkg::*;

	qedc_item_t   in_item;
	qedc_item_t   item_s1;
	logic         valid_s1;
	logic         advance;
	qedc_result_t result;

	// Gather the input fields into one transaction.
	assign in_item.cmd        = qedc_cmd_t'(command);
	assign in_item.time_us    = time_us;
	assign in_item.pins       = {pin_a, pin_b};
	assign in_item.load_value = load_value;

	qedc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	qedc_update u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result)
	);

	// Split the result transaction onto the output ports.
	assign position    = result.position;
	assign step_delta  = result.step_delta;
	assign delta_valid = result.delta_valid;
	assign edge_taken  = result.edge_taken;

endmodule

`default_nettype wire

>>> tb/tb_quadrature_encoder_debounced_counter_core.sv
// Testbench for the debounced quadrature encoder counter, with directed and random transactions.
`timescale 1ns / 1ps

module tb_quadrature_encoder_debounced_counter_core;
	import qedc_pkg::*;

	// Count step for {old A, old B, new A, new B}.
	localparam int QUAD_STEPS [16] = '{
		 0, -1,  1,  0,
		 1,  0,  0, -1,
		-1,  0,  0,  1,
		 0,  1, -1,  0
	};
	localparam int DELTA_LIMIT = 4;
	localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd1000;
	localparam int PHASE_ITEMS = 250;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 4;
	// One turn of the encoder in Gray order, {A, B}.
	localparam logic [1:0] GRAY_TURN [4] = '{2'b00, 2'b01, 2'b11, 2'b10};
	// Pin sequence that walks every old/new pin pair once, starting from 2'b11.
	localparam logic [1:0] PAIR_WALK [16] = '{
		2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1,
		2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	qedc_cmd_t command;
	logic [31:0] time_us;
	logic pin_a;
	logic pin_b;
	logic signed [31:0] load_value;
	logic cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] position;
	logic signed [3:0] step_delta;
	logic delta_valid;
	logic edge_taken;

	// Predicted encoder state and the debounce setting it uses.
	logic [31:0] enc_count;
	logic [1:0] enc_prev_pins;
	logic [31:0] enc_last_stamp;
	logic [31:0] enc_consumed;
	logic [15:0] debounce_val;

	qedc_result_t expected_results[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic [31:0] gen_stamp = '0;

	quadrature_encoder_debounced_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.time_us(time_us),
		.pin_a(pin_a),
		.pin_b(pin_b),
		.load_value(load_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position(position),
		.step_delta(step_delta),
		.delta_valid(delta_valid),
		.edge_taken(edge_taken)
	);

	always #6 clk = ~clk;

	// Works out the result of one accepted transaction and advances the predicted state.
	function automatic qedc_result_t predict_encoder_result(qedc_cmd_t cmd, logic [31:0] stamp,
			logic [1:0] pins, logic [31:0] value);
		qedc_result_t res;
		logic [31:0] elapsed;
		logic [31:0] diff;
		logic [31:0] mag;
		int delta;
		res = '0;
		delta = 0;
		case (cmd)
			CMD_EDGE: begin
				elapsed = stamp - enc_last_stamp;
				if (elapsed >= {16'd0, debounce_val}) begin
					enc_last_stamp = stamp;
					enc_count = enc_count + 32'(QUAD_STEPS[{enc_prev_pins, pins}]);
					enc_prev_pins = pins;
					res.edge_taken = 1'b1;
				end
			end
			CMD_CONSUME: begin
				diff = enc_count - enc_consumed;
				if (diff != 0) begin
					if (!diff[31]) begin
						delta = (diff > DELTA_LIMIT) ? DELTA_LIMIT : int'(diff);
					end else begin
						mag = -diff;
						delta = (mag > DELTA_LIMIT) ? -DELTA_LIMIT : -int'(mag);
					end
					enc_consumed = enc_count;
					res.delta_valid = 1'b1;
				end
			end
			CMD_LOAD: begin
				enc_count = value;
			end
			default: begin
				enc_prev_pins = pins;
			end
		endcase
		res.position = enc_count;
		res.step_delta = 4'(delta);
		return res;
	endfunction

	task automatic report_error(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Predict on every accepted input transaction, check every accepted result.
	always @(posedge clk) begin : result_check
		qedc_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_encoder_result(command, time_us,
					{pin_a, pin_b}, load_value));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_error("result with no transaction pending");
				end else begin
					want = expected_results.pop_front();
					if (position !== want.position)
						report_error($sformatf("position expected %0d got %0d",
							want.position, position));
					if (step_delta !== want.step_delta)
						report_error($sformatf("step_delta expected %0d got %0d",
							want.step_delta, step_delta));
					if (delta_valid !== want.delta_valid)
						report_error($sformatf("delta_valid expected %0b got %0b",
							want.delta_valid, delta_valid));
					if (edge_taken !== want.edge_taken)
						report_error($sformatf("edge_taken expected %0b got %0b",
							want.edge_taken, edge_taken));
				end
			end
		end
	end

	// Offers one transaction, with random idle cycles first, and returns once it is taken.
	task automatic send_transaction(qedc_cmd_t cmd, logic [31:0] stamp, logic [1:0] pins,
			logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		time_us <= stamp;
		pin_a <= pins[1];
		pin_b <= pins[0];
		load_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the debounce register while the block is idle.
	task automatic write_debounce(logic [15:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		debounce_val = value;
	endtask

	// Reset debounce: rejection just below the limit, acceptance at it, consume after reset.
	task automatic test_after_reset();
		send_transaction(CMD_EDGE, 32'd999, 2'b01, 32'd0);
		send_transaction(CMD_EDGE, 32'd1000, 2'b10, 32'hFFFF_FFFF);
		send_transaction(CMD_CONSUME, 32'd1000, 2'b00, 32'd0);
		send_transaction(CMD_CONSUME, 32'd1000, 2'b11, 32'd0);
		send_transaction(CMD_CAPTURE, 32'd1001, 2'b11, 32'd0);
		send_transaction(CMD_EDGE, 32'd1500, 2'b11, 32'd0);
	endtask

	// Every old/new pin pair once, with no debounce.
	task automatic test_quadrature_table();
		write_debounce(16'd0);
		for (int i = 0; i < 16; i++)
			send_transaction(CMD_EDGE, 32'(i + 1), PAIR_WALK[i], $urandom());
	endtask

	// Count wrap at the signed limits and clamping of large consume jumps.
	task automatic test_wrap_and_clamp();
		send_transaction(CMD_LOAD, 32'd50, 2'b00, 32'h7FFF_FFFF);
		send_transaction(CMD_CONSUME, 32'd60, 2'b00, 32'd0);
		send_transaction(CMD_CAPTURE, 32'd70, 2'b00, 32'd0);
		send_transaction(CMD_EDGE, 32'd100, 2'b10, 32'd0);
		send_transaction(CMD_CONSUME, 32'd110, 2'b00, 32'd0);
		send_transaction(CMD_LOAD, 32'd120, 2'b00, 32'h7FFF_FFFF);
		send_transaction(CMD_CONSUME, 32'd130, 2'b00, 32'd0);
		send_transaction(CMD_LOAD, 32'd140, 2'b00, 32'h0000_0000);
		send_transaction(CMD_CONSUME, 32'd150, 2'b00, 32'd0);
		send_transaction(CMD_LOAD, 32'd160, 2'b00, 32'h8000_0000);
		send_transaction(CMD_CONSUME, 32'd170, 2'b00, 32'd0);
	endtask

	// Largest debounce, with the timestamp wrapping past zero.
	task automatic test_debounce_wrap();
		write_debounce(16'hFFFF);
		send_transaction(CMD_EDGE, 32'hFFFF_0000, 2'b10, 32'd0);
		send_transaction(CMD_EDGE, 32'hFFFF_FFFE, 2'b11, 32'd0);
		send_transaction(CMD_EDGE, 32'hFFFF_FFFF, 2'b11, 32'd0);
		send_transaction(CMD_EDGE, 32'h0000_FFFE, 2'b01, 32'd0);
	endtask

	// Mostly a turning shaft with clean edges and consumes, mixed with bounce and noise.
	task automatic run_random_phase(int count);
		int roll;
		int gray_pos;
		int shaft_dir;
		logic [31:0] value;
		gray_pos = 0;
		shaft_dir = 1;
		send_transaction(CMD_CAPTURE, gen_stamp, GRAY_TURN[0], $urandom());
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			value = $urandom();
			if (roll < 60) begin
				if ($urandom_range(15) == 0)
					shaft_dir = -shaft_dir;
				if ($urandom_range(7) != 0)
					gray_pos = (gray_pos + shaft_dir) & 3;
				gen_stamp += 32'(debounce_val) + $urandom_range(0, 40);
				send_transaction(CMD_EDGE, gen_stamp, GRAY_TURN[gray_pos], value);
			end else if (roll < 75) begin
				send_transaction(CMD_CONSUME, gen_stamp, 2'($urandom()), value);
			end else if (roll < 83) begin
				// Contact bounce: close to the last edge, pins at random.
				send_transaction(CMD_EDGE, gen_stamp + $urandom_range(0, debounce_val),
					2'($urandom()), value);
			end else if (roll < 88) begin
				// A missed step makes both channels change at once.
				gray_pos = (gray_pos + 2) & 3;
				gen_stamp += 32'(debounce_val) + $urandom_range(0, 40);
				send_transaction(CMD_EDGE, gen_stamp, GRAY_TURN[gray_pos], value);
			end else if (roll < 92) begin
				if ($urandom_range(1) == 0)
					value = 32'h7FFF_FFFE + $urandom_range(0, 3);
				send_transaction(CMD_LOAD, gen_stamp, 2'($urandom()), value);
			end else if (roll < 95) begin
				gray_pos = $urandom_range(3);
				send_transaction(CMD_CAPTURE, gen_stamp, GRAY_TURN[gray_pos], value);
			end else begin
				send_transaction(qedc_cmd_t'($urandom_range(3)), $urandom(), 2'($urandom()),
					value);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_EDGE;
		time_us <= '0;
		pin_a <= 1'b0;
		pin_b <= 1'b0;
		load_value <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		out_stall <= 1'b0;
		enc_count = '0;
		enc_prev_pins = '0;
		enc_last_stamp = '0;
		enc_consumed = '0;
		debounce_val = DEBOUNCE_AT_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_quadrature_table();
		test_wrap_and_clamp();
		test_debounce_wrap();

		// Random phases, each with its own debounce and idle pattern.
		write_debounce(16'd0);
		send_idle_pct = 0;
		stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		write_debounce(16'hFFFF);
		send_idle_pct = 53;
		stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		write_debounce(16'd1);
		send_idle_pct = 0;
		stall_pct = 53;
		run_random_phase(PHASE_ITEMS);
		write_debounce(16'($urandom_range(2, 5000)));
		send_idle_pct = 37;
		stall_pct = 37;
		run_random_phase(PHASE_ITEMS);

		drain_results();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Ends a run that hangs.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/qedc_pkg.sv
rtl/qedc_in_stage.sv
rtl/qedc_update.sv
rtl/quadrature_encoder_debounced_counter_core.sv
tb/tb_quadrature_encoder_debounced_counter_core.sv
